### sv/geo_hav_pkg.sv
// ----------------------------------------------------------------------------
// geo_hav_pkg
// Shared constants, types and helpers of the haversine offset core.
// ----------------------------------------------------------------------------
package geo_hav_pkg;

   localparam int unsigned COORD_W   = 29;   // coordinate, degrees in Q8.20
   localparam int unsigned OFF_W     = 26;   // signed metres
   localparam int unsigned FRAC_BITS = 20;
   localparam int unsigned ABS_W     = 29;   // magnitude of a coordinate difference
   localparam int unsigned DEG_W     = 28;   // folded angle, at most 180 degrees
   localparam int unsigned RAD_W     = 32;   // radians, Q30
   localparam int unsigned ANG_W     = 31;   // radians up to pi/2, Q30
   localparam int unsigned Q_BITS    = 30;
   localparam int unsigned TERM_W    = 32;
   localparam int unsigned SUM_W     = 34;
   localparam int unsigned DIST_W    = 25;
   localparam int unsigned RADIUS_W  = 25;
   localparam int unsigned TERMS     = 9;
   localparam int unsigned RAD_LAT   = 4;
   localparam int unsigned SIN_LAT   = 2 + 2 * TERMS;
   localparam int unsigned ASIN_BITS = ANG_W;

   localparam logic [RAD_W-1:0]    PI_Q30      = 32'd3373259426;
   localparam logic [ANG_W-1:0]    HALF_PI_Q30 = 31'd1686629713;
   localparam logic [ANG_W-1:0]    ONE_Q30     = 31'd1073741824;
   localparam logic [RADIUS_W-1:0] RADIUS_X4   = 25'd25478515;

   localparam logic [ABS_W-1:0] TURN    = ABS_W'(360 * (2 ** FRAC_BITS));
   localparam logic [ABS_W-1:0] HALF_F  = ABS_W'(180 * (2 ** FRAC_BITS));
   localparam logic [ABS_W-1:0] QTR_F   = ABS_W'(90 * (2 ** FRAC_BITS));
   localparam logic [ABS_W-1:0] HALF_F1 = ABS_W'(180 * (2 ** (FRAC_BITS + 1)));
   localparam logic [ABS_W-1:0] QTR_F1  = ABS_W'(90 * (2 ** (FRAC_BITS + 1)));

   localparam logic [COORD_W-1:0] ORIGIN_FIRST_RESET  = 29'd122171393;
   localparam logic [COORD_W-1:0] ORIGIN_SECOND_RESET = 29'd41860444;

   typedef enum logic [0:0] {
      CSR_ORIGIN_FIRST  = 1'b0,
      CSR_ORIGIN_SECOND = 1'b1
   } csr_index_type;

   // one Taylor step in flight
   typedef struct packed {
      logic [TERM_W-1:0]       x2;
      logic [TERM_W-1:0]       term;
      logic signed [SUM_W-1:0] sum;
   } term_type;

   // per-request data riding alongside the arcsine search
   typedef struct packed {
      logic              gt_first;
      logic              gt_second;
      logic [DIST_W-1:0] dist_first;
   } side_type;

   // divisor of the k-th Taylor term: (2k)(2k+1)
   function automatic int unsigned tay_div(input int unsigned k);
      return (2 * k) * (2 * k + 1);
   endfunction

endpackage

### sv/geo_offset_haversine_core.sv
// ----------------------------------------------------------------------------
// geo_offset_haversine_core
// Signed haversine offsets in metres of a GPS point from a set origin.
// ----------------------------------------------------------------------------
// A request carries one point (two signed Q8.20 coordinates) on req_*, with
// req_valid/req_stall. The result, one pair of signed metre offsets, leaves
// on rsp_* with rsp_valid/rsp_stall. The user must write the origin on csr_*
// only while the core is idle; the core itself has no check for this.
// Throughput: one request per cycle while req_stall is low. The depth from
// acceptance to rsp_valid is set mostly by the arcsine search: 31 bit cells
// in a row, each holding a 20-stage Taylor sine pipeline plus a compare
// stage, after 4 front stages, a 4-stage degree-to-radian unit, a 20-stage
// sine/cosine and the product stage, and before the scaling and output stages.
// The result side has a two-entry output buffer; the whole pipeline holds
// only when both entries are full, so one result may wait while requests
// still flow. req_stall follows from buffer occupancy alone.
// Reset (synchronous) empties the pipeline and buffer and loads the default
// origin.
// ----------------------------------------------------------------------------
module geo_offset_haversine_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [geo_hav_pkg::COORD_W-1:0] req_point_first,
   input  logic signed [geo_hav_pkg::COORD_W-1:0] req_point_second,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [geo_hav_pkg::OFF_W-1:0] rsp_offset_first,
   output logic signed [geo_hav_pkg::OFF_W-1:0] rsp_offset_second,
   input  logic                                 csr_write_en,
   input  geo_hav_pkg::csr_index_type           csr_index,
   input  logic [geo_hav_pkg::COORD_W-1:0]      csr_data
);
   import geo_hav_pkg::*;

   localparam int unsigned D_W = COORD_W + 1;

   logic                    en;
   logic [1:0]              count_ff;
   logic signed [COORD_W-1:0] org1_ff, org2_ff;

   // front stages
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [D_W-1:0]   d1_ff, d2_ff, d1_in, d2_in;
   logic signed [COORD_W-1:0] o1_ff;
   logic [ABS_W-1:0]        m1_ff, m2_ff, mo_ff, m1_in, m2_in, mo_in;
   logic [ABS_W-1:0]        w1_ff, w2_ff, wc_ff;
   logic [DEG_W-1:0]        a1_ff, a2_ff, ac_ff;
   logic [1:0]              gt2_ff, gt3_ff, gt4_ff;

   logic [RAD_W-1:0]        rad1, rad2, radc;
   logic                    rdv_ff [RAD_LAT];
   logic [1:0]              rdg_ff [RAD_LAT];

   logic [RAD_W+RADIUS_W-1:0] dist1_prod;
   side_type                sd_in;
   logic                    sdv_ff [SIN_LAT];
   side_type                sds_ff [SIN_LAT];
   logic [ANG_W-1:0]        cos_o, sin_d;

   logic [2*ANG_W-1:0]      y_prod;
   logic [TERM_W-1:0]       y_raw;
   logic                    yv_ff;
   logic [ANG_W-1:0]        y_ff, y_in;
   side_type                ys_ff;

   logic                    av    [0:ASIN_BITS];
   logic [ANG_W-1:0]        ay    [0:ASIN_BITS];
   logic [ANG_W-1:0]        at    [0:ASIN_BITS];
   side_type                aside [0:ASIN_BITS];

   logic [RAD_W+RADIUS_W-1:0] dist2_prod;
   logic                    d2v_ff;
   logic [DIST_W-1:0]       dist2_ff;
   side_type                d2s_ff;

   logic [OFF_W-1:0]        off1_in, off2_in;
   logic [OFF_W-1:0]        b0_first_ff, b0_second_ff, b1_first_ff, b1_second_ff;
   logic                    push, pop;

   assign en        = (count_ff != 2'd2);
   assign req_stall = !en;

   // origin registers
   always_ff @(posedge clock) begin
      if (reset) begin
         org1_ff <= ORIGIN_FIRST_RESET;
         org2_ff <= ORIGIN_SECOND_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORIGIN_FIRST:  org1_ff <= csr_data;
            CSR_ORIGIN_SECOND: org2_ff <= csr_data;
         endcase
      end
   end

   // stage 1: differences; stage 2: magnitudes; 3: wrap; 4: fold (first to 180 degrees, others to a quadrant)
   assign d1_in = D_W'(req_point_first) - D_W'(org1_ff);
   assign d2_in = D_W'(req_point_second) - D_W'(org2_ff);
   assign m1_in = ABS_W'(d1_ff[D_W-1] ? -d1_ff : d1_ff);
   assign m2_in = ABS_W'(d2_ff[D_W-1] ? -d2_ff : d2_ff);
   assign mo_in = ABS_W'(o1_ff[COORD_W-1] ? -D_W'(o1_ff) : D_W'(o1_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
         o1_ff  <= org1_ff;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         mo_ff  <= mo_in;
         gt2_ff <= {!d1_ff[D_W-1] && (d1_ff != '0), !d2_ff[D_W-1] && (d2_ff != '0)};
         w1_ff  <= (m1_ff >= TURN) ? m1_ff - TURN : m1_ff;
         w2_ff  <= (m2_ff >= HALF_F1) ? m2_ff - HALF_F1 : m2_ff;
         wc_ff  <= (mo_ff >= HALF_F) ? mo_ff - HALF_F : mo_ff;
         gt3_ff <= gt2_ff;
         a1_ff  <= DEG_W'((w1_ff > HALF_F) ? TURN - w1_ff : w1_ff);
         a2_ff  <= DEG_W'((w2_ff > QTR_F1) ? HALF_F1 - w2_ff : w2_ff);
         // cosine as the sine of the distance to ninety degrees
         ac_ff  <= DEG_W'((wc_ff <= QTR_F) ? QTR_F - wc_ff : wc_ff - QTR_F);
         gt4_ff <= gt3_ff;
      end
   end

   geo_hav_rad #(.SHIFT(FRAC_BITS)) u_rad_first (
      .clock (clock), .en (en), .deg (a1_ff), .rad (rad1)
   );
   // half-angle of the second difference: one more fraction bit
   geo_hav_rad #(.SHIFT(FRAC_BITS + 1)) u_rad_second (
      .clock (clock), .en (en), .deg (a2_ff), .rad (rad2)
   );
   geo_hav_rad #(.SHIFT(FRAC_BITS)) u_rad_cos (
      .clock (clock), .en (en), .deg (ac_ff), .rad (radc)
   );

   geo_hav_sin u_sin_cos (
      .clock (clock), .en (en), .x (ANG_W'(radc)), .sin_x (cos_o)
   );
   geo_hav_sin u_sin_second (
      .clock (clock), .en (en), .x (ANG_W'(rad2)), .sin_x (sin_d)
   );

   assign dist1_prod       = rad1 * RADIUS_X4;
   assign sd_in.gt_first   = rdg_ff[RAD_LAT-1][1];
   assign sd_in.gt_second  = rdg_ff[RAD_LAT-1][0];
   assign sd_in.dist_first = DIST_W'(dist1_prod >> (2 * TERM_W - 32));

   assign y_prod = cos_o * sin_d;
   assign y_raw  = y_prod[Q_BITS+TERM_W-1:Q_BITS];
   assign y_in   = (y_raw > TERM_W'(ONE_Q30)) ? ONE_Q30 : ANG_W'(y_raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int i = 0; i < RAD_LAT; i++) rdv_ff[i] <= 1'b0;
         for (int i = 0; i < SIN_LAT; i++) sdv_ff[i] <= 1'b0;
         yv_ff  <= 1'b0;
         d2v_ff <= 1'b0;
      end else if (en) begin
         v1_ff     <= req_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         rdv_ff[0] <= v4_ff;
         for (int i = 1; i < RAD_LAT; i++) rdv_ff[i] <= rdv_ff[i-1];
         sdv_ff[0] <= rdv_ff[RAD_LAT-1];
         for (int i = 1; i < SIN_LAT; i++) sdv_ff[i] <= sdv_ff[i-1];
         yv_ff     <= sdv_ff[SIN_LAT-1];
         d2v_ff    <= av[ASIN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rdg_ff[0] <= gt4_ff;
         for (int i = 1; i < RAD_LAT; i++) rdg_ff[i] <= rdg_ff[i-1];
         sds_ff[0] <= sd_in;
         for (int i = 1; i < SIN_LAT; i++) sds_ff[i] <= sds_ff[i-1];
         y_ff     <= y_in;
         ys_ff    <= sds_ff[SIN_LAT-1];
         dist2_ff <= DIST_W'(dist2_prod >> (2 * TERM_W - 32));
         d2s_ff   <= aside[ASIN_BITS];
      end
   end

   // arcsine: one cell per result bit, most significant first
   assign av[0]    = yv_ff;
   assign ay[0]    = y_ff;
   assign at[0]    = '0;
   assign aside[0] = ys_ff;

   for (genvar j = 0; j < ASIN_BITS; j++) begin : g_asin
      geo_hav_asin_cell #(.BIT(ASIN_BITS - 1 - j)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (av[j]),
         .in_y      (ay[j]),
         .in_t      (at[j]),
         .in_side   (aside[j]),
         .out_valid (av[j+1]),
         .out_y     (ay[j+1]),
         .out_t     (at[j+1]),
         .out_side  (aside[j+1])
      );
   end

   // central angle is twice the search result
   assign dist2_prod = {at[ASIN_BITS], 1'b0} * RADIUS_X4;

   assign off1_in = d2s_ff.gt_first ? OFF_W'(d2s_ff.dist_first)
                                    : -OFF_W'(d2s_ff.dist_first);
   assign off2_in = d2s_ff.gt_second ? OFF_W'(dist2_ff) : -OFF_W'(dist2_ff);

   // two-entry output buffer
   assign push = d2v_ff && en;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push && (count_ff == 2'd0 || (count_ff == 2'd1 && pop))) begin
         b0_first_ff  <= off1_in;
         b0_second_ff <= off2_in;
      end else if (pop) begin
         b0_first_ff  <= b1_first_ff;
         b0_second_ff <= b1_second_ff;
      end
      if (push && count_ff == 2'd1 && !pop) begin
         b1_first_ff  <= off1_in;
         b1_second_ff <= off2_in;
      end
   end

   assign rsp_valid         = (count_ff != 2'd0);
   assign rsp_offset_first  = b0_first_ff;
   assign rsp_offset_second = b0_second_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("output buffer overfilled");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(d2v_ff) && $stable(yv_ff))
      else $error("pipeline moved while held");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && d2v_ff && !req_stall) |=> rsp_valid)
      else $error("finished request not presented");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("buffer count wrong after drain");

endmodule

### sv/geo_hav_term.sv
// ----------------------------------------------------------------------------
// geo_hav_term
// One Taylor term cell: multiply by x^2, divide by a constant, accumulate.
// ----------------------------------------------------------------------------
module geo_hav_term #(
   parameter int unsigned DIV = 6,
   parameter bit          NEG = 1'b1
) (
   input  logic                  clock,
   input  logic                  en,
   input  geo_hav_pkg::term_type in_data,
   output geo_hav_pkg::term_type out_data
);
   import geo_hav_pkg::*;

   localparam int unsigned K      = TERM_W + $clog2(DIV);
   localparam int unsigned MAG_W  = TERM_W + 1;
   localparam int unsigned WIDE_W = 2 * TERM_W + 2;
   localparam logic [WIDE_W-1:0] ONE_K = WIDE_W'(1) << K;
   localparam logic [MAG_W-1:0]  MAG   =
      MAG_W'((ONE_K + WIDE_W'(DIV - 1)) / WIDE_W'(DIV));

   logic [2*TERM_W-1:0]      prod_a;
   logic [TERM_W+MAG_W-1:0]  prod_b;
   logic [TERM_W-1:0]        quot;
   logic signed [SUM_W-1:0]  quot_s;
   term_type                 a_ff, a_in;
   term_type                 b_ff, b_in;

   assign prod_a = in_data.term * in_data.x2;

   always_comb begin
      a_in      = in_data;
      a_in.term = prod_a[Q_BITS+TERM_W-1:Q_BITS];
   end

   // reciprocal multiply, exact for any 32-bit numerator
   assign prod_b = a_ff.term * MAG;
   assign quot   = TERM_W'(prod_b >> K);
   assign quot_s = $signed(SUM_W'(quot));

   always_comb begin
      b_in      = a_ff;
      b_in.term = quot;
      b_in.sum  = NEG ? (a_ff.sum - quot_s) : (a_ff.sum + quot_s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   assign out_data = b_ff;

endmodule

### sv/geo_hav_sin.sv
// ----------------------------------------------------------------------------
// geo_hav_sin
// Pipelined sine on [0, pi/2] in Q30: a row of Taylor term cells.
// ----------------------------------------------------------------------------
module geo_hav_sin (
   input  logic                          clock,
   input  logic                          en,
   input  logic [geo_hav_pkg::ANG_W-1:0] x,
   output logic [geo_hav_pkg::ANG_W-1:0] sin_x
);
   import geo_hav_pkg::*;

   logic [2*ANG_W-1:0] sq;
   term_type           head_ff, head_in;
   term_type           chain [0:TERMS];
   logic [ANG_W-1:0]   sin_ff, sin_in;

   assign sq = x * x;

   always_comb begin
      head_in.x2   = sq[Q_BITS+TERM_W-1:Q_BITS];
      head_in.term = TERM_W'(x);
      head_in.sum  = $signed(SUM_W'(x));
   end

   assign chain[0] = head_ff;

   for (genvar k = 0; k < TERMS; k++) begin : g_term
      geo_hav_term #(
         .DIV (tay_div(k + 1)),
         .NEG (1'((k + 1) % 2))
      ) u_term (
         .clock    (clock),
         .en       (en),
         .in_data  (chain[k]),
         .out_data (chain[k+1])
      );
   end

   always_comb begin
      if (chain[TERMS].sum < 0) begin
         sin_in = '0;
      end else if (chain[TERMS].sum > $signed(SUM_W'(ONE_Q30))) begin
         sin_in = ONE_Q30;
      end else begin
         sin_in = ANG_W'(chain[TERMS].sum);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         head_ff <= head_in;
         sin_ff  <= sin_in;
      end
   end

   assign sin_x = sin_ff;

endmodule

### sv/geo_hav_rad.sv
// ----------------------------------------------------------------------------
// geo_hav_rad
// Degrees in fixed point to Q30 radians, floored; four stages.
// ----------------------------------------------------------------------------
module geo_hav_rad #(
   parameter int unsigned SHIFT = geo_hav_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [geo_hav_pkg::DEG_W-1:0] deg,
   output logic [geo_hav_pkg::RAD_W-1:0] rad
);
   import geo_hav_pkg::*;

   // divide by 180 * 2^SHIFT as a shift by SHIFT+2 and a long division by 45
   localparam int unsigned P_W   = DEG_W + RAD_W;
   localparam int unsigned Q_LSB = SHIFT + 2;
   localparam int unsigned Q_W   = P_W - Q_LSB;
   localparam int unsigned LO_W  = 19;
   localparam int unsigned HI_W  = Q_W - LO_W;
   localparam int unsigned D_ODD = 45;
   localparam int unsigned D_LOG = 6;
   localparam int unsigned NX_W  = LO_W + D_LOG;
   localparam int unsigned K1    = HI_W + D_LOG;
   localparam int unsigned K2    = NX_W + D_LOG;
   localparam int unsigned M1_W  = HI_W + 1;
   localparam int unsigned M2_W  = NX_W + 1;
   localparam logic [M1_W-1:0] MAG1 = M1_W'(((64'd1 << K1) + 64'(D_ODD - 1)) / 64'(D_ODD));
   localparam logic [M2_W-1:0] MAG2 = M2_W'(((64'd1 << K2) + 64'(D_ODD - 1)) / 64'(D_ODD));

   logic [P_W-1:0]        p_ff;
   logic [HI_W-1:0]       hi_ff, qh_ff, qh2_ff, rh_full;
   logic [LO_W-1:0]       lo_ff, ql;
   logic [2*HI_W:0]       prod_hi;
   logic [NX_W-1:0]       nx_ff, nx_in;
   logic [NX_W+M2_W-1:0]  prod_nx;
   logic [RAD_W-1:0]      rad_ff, rad_in;

   assign prod_hi = p_ff[P_W-1:Q_LSB+LO_W] * MAG1;
   assign rh_full = hi_ff - HI_W'(qh_ff * D_ODD);
   assign nx_in   = {rh_full[D_LOG-1:0], lo_ff};
   assign prod_nx = nx_ff * MAG2;
   assign ql      = LO_W'(prod_nx >> K2);
   assign rad_in  = RAD_W'({qh2_ff, ql});

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= deg * PI_Q30;
         hi_ff  <= p_ff[P_W-1:Q_LSB+LO_W];
         lo_ff  <= p_ff[Q_LSB+LO_W-1:Q_LSB];
         qh_ff  <= HI_W'(prod_hi >> K1);
         nx_ff  <= nx_in;
         qh2_ff <= qh_ff;
         rad_ff <= rad_in;
      end
   end

   assign rad = rad_ff;

endmodule

### sv/geo_hav_asin_cell.sv
// ----------------------------------------------------------------------------
// geo_hav_asin_cell
// One bit of the arcsine search: try the bit, keep it if it stays <= pi/2 and sin stays <= y.
// ----------------------------------------------------------------------------
module geo_hav_asin_cell #(
   parameter int unsigned BIT = 30
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [geo_hav_pkg::ANG_W-1:0] in_y,
   input  logic [geo_hav_pkg::ANG_W-1:0] in_t,
   input  geo_hav_pkg::side_type         in_side,
   output logic                          out_valid,
   output logic [geo_hav_pkg::ANG_W-1:0] out_y,
   output logic [geo_hav_pkg::ANG_W-1:0] out_t,
   output geo_hav_pkg::side_type         out_side
);
   import geo_hav_pkg::*;

   localparam logic [ANG_W-1:0] BIT_MASK = ANG_W'(1) << BIT;

   logic [ANG_W-1:0] sin_c;
   logic [ANG_W-1:0] cand;
   logic             take;
   logic             dv_ff   [SIN_LAT];
   logic [ANG_W-1:0] dy_ff   [SIN_LAT];
   logic [ANG_W-1:0] dt_ff   [SIN_LAT];
   side_type         ds_ff   [SIN_LAT];
   logic             v_ff;
   logic [ANG_W-1:0] y_ff, t_ff, t_in;
   side_type         s_ff;

   geo_hav_sin u_sin (
      .clock (clock),
      .en    (en),
      .x     (in_t | BIT_MASK),
      .sin_x (sin_c)
   );

   assign cand = dt_ff[SIN_LAT-1] | BIT_MASK;
   assign take = (cand <= HALF_PI_Q30) && (sin_c <= dy_ff[SIN_LAT-1]);
   assign t_in = take ? cand : dt_ff[SIN_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIN_LAT; i++) dv_ff[i] <= 1'b0;
         v_ff <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= in_valid;
         for (int i = 1; i < SIN_LAT; i++) dv_ff[i] <= dv_ff[i-1];
         v_ff <= dv_ff[SIN_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dy_ff[0] <= in_y;
         dt_ff[0] <= in_t;
         ds_ff[0] <= in_side;
         for (int i = 1; i < SIN_LAT; i++) begin
            dy_ff[i] <= dy_ff[i-1];
            dt_ff[i] <= dt_ff[i-1];
            ds_ff[i] <= ds_ff[i-1];
         end
         y_ff <= dy_ff[SIN_LAT-1];
         t_ff <= t_in;
         s_ff <= ds_ff[SIN_LAT-1];
      end
   end

   assign out_valid = v_ff;
   assign out_y     = y_ff;
   assign out_t     = t_ff;
   assign out_side  = s_ff;

endmodule

### tb/tb_geo_offset_haversine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_geo_offset_haversine_core
// Self-checking bench for the haversine offset core.
// ----------------------------------------------------------------------------
// A fixed-point model of the offset maths predicts each pair of offsets from
// the origin in force. Requests idle and results stall at random,
// and the origin is moved between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb_geo_offset_haversine_core;
   import geo_hav_pkg::*;

   localparam int COORD_MAX = 188743680;
   localparam int COORD_MIN = -188743680;
   localparam int DEG       = 1 << FRAC_BITS;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 800;

   localparam longint unsigned PI_Q    = 64'd3373259426;
   localparam longint unsigned HALF_PI = 64'd1686629713;
   localparam longint unsigned ONE_Q   = 64'd1073741824;
   localparam longint unsigned RADIUS  = 64'd25478515;

   typedef struct {
      logic signed [OFF_W-1:0] first;
      logic signed [OFF_W-1:0] second;
   } offset_pair_type;

   class offset_book;
      longint           org_first;
      longint           org_second;
      offset_pair_type  pending[$];
      int               errors;

      function new();
         org_first  = longint'($signed(ORIGIN_FIRST_RESET));
         org_second = longint'($signed(ORIGIN_SECOND_RESET));
         errors     = 0;
      endfunction

      function longint unsigned to_rad(longint unsigned m, int fb);
         return (m * PI_Q) / (64'd180 << fb);
      endfunction

      function longint unsigned sine(longint unsigned x);
         longint unsigned x2, term;
         longint          sum;
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > longint'(ONE_Q)) sum = longint'(ONE_Q);
         return longint'(sum);
      endfunction

      function longint unsigned abs_sine(longint unsigned mag, int fb);
         longint unsigned half, m;
         half = 64'd180 << fb;
         m = mag % half;
         if (m > (64'd90 << fb)) m = half - m;
         return sine(to_rad(m, fb));
      endfunction

      function longint unsigned abs_cosine(longint v);
         longint unsigned mag, w, q;
         mag = v < 0 ? longint'(-v) : longint'(v);
         w = mag % (64'd180 << FRAC_BITS);
         q = 64'd90 << FRAC_BITS;
         return abs_sine(w <= q ? q - w : w - q, FRAC_BITS);
      endfunction

      function longint unsigned arcsine(longint unsigned y);
         longint unsigned t, c;
         t = 0;
         for (int b = 30; b >= 0; b--) begin
            c = t | (64'd1 << b);
            if (c <= HALF_PI && sine(c) <= y) t = c;
         end
         return t;
      endfunction

      function longint unsigned metres(longint unsigned c);
         return (c * RADIUS) >> 32;
      endfunction

      function void note_request(longint p1, longint p2);
         longint unsigned turn, m1, m2, y, dist1, dist2;
         longint          d1, d2, r1, r2;
         offset_pair_type e;
         turn = 64'd360 << FRAC_BITS;
         d1 = p1 - org_first;
         d2 = p2 - org_second;
         m1 = d1 < 0 ? longint'(-d1) : longint'(d1);
         m2 = d2 < 0 ? longint'(-d2) : longint'(d2);
         m1 = m1 % turn;
         if (m1 > (64'd180 << FRAC_BITS)) m1 = turn - m1;
         dist1 = metres(to_rad(m1, FRAC_BITS));
         // half-angle of the second difference: one extra fraction bit
         y = (abs_cosine(org_first) * abs_sine(m2, FRAC_BITS + 1)) >> 30;
         if (y > ONE_Q) y = ONE_Q;
         dist2 = metres(2 * arcsine(y));
         r1 = org_first < p1 ? longint'(dist1) : -longint'(dist1);
         r2 = org_second < p2 ? longint'(dist2) : -longint'(dist2);
         e.first  = r1[OFF_W-1:0];
         e.second = r2[OFF_W-1:0];
         pending.push_back(e);
      endfunction

      function void check_result(logic signed [OFF_W-1:0] o1,
                                 logic signed [OFF_W-1:0] o2);
         offset_pair_type e;
         if (pending.size() == 0) begin
            $error("result (%0d, %0d) with no request outstanding", o1, o2);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (o1 !== e.first) begin
            $error("offset_first: expected %0d, got %0d", e.first, o1);
            errors++;
         end
         if (o2 !== e.second) begin
            $error("offset_second: expected %0d, got %0d", e.second, o2);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [COORD_W-1:0]   req_point_first;
   logic signed [COORD_W-1:0]   req_point_second;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [OFF_W-1:0]     rsp_offset_first;
   logic signed [OFF_W-1:0]     rsp_offset_second;
   logic                        csr_write_en;
   csr_index_type               csr_index;
   logic [COORD_W-1:0]          csr_data;

   offset_book book = new();
   int         idle_cycles;
   int         stall_left;
   bit         calm_rsp;
   bit         calm_req;

   geo_offset_haversine_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_point_first   (req_point_first),
      .req_point_second  (req_point_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_offset_first  (rsp_offset_first),
      .rsp_offset_second (rsp_offset_second),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int gap_len(bit calm);
      if (calm) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 3);
   endfunction

   function automatic longint clamp(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // result side: random stall, checked on acceptance
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            book.check_result(rsp_offset_first, rsp_offset_second);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            stall_left <= gap_len(calm_rsp);
            rsp_stall  <= 1'b0;
         end
      end
   end

   // watchdog: cycles with neither side moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** geo_offset_haversine_core: FAILED **");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic send_request(longint p1, longint p2);
      int gap;
      gap = gap_len(calm_req);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_point_first  <= p1[COORD_W-1:0];
      req_point_second <= p2[COORD_W-1:0];
      do @(posedge clock); while (req_stall);
      book.note_request(p1, p2);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_origin(longint o1, longint o2);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_ORIGIN_FIRST;
      csr_data     <= o1[COORD_W-1:0];
      @(posedge clock);
      csr_index    <= CSR_ORIGIN_SECOND;
      csr_data     <= o2[COORD_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      book.org_first  = o1;
      book.org_second = o2;
   endtask

   task automatic random_requests(int count);
      longint p1, p2;
      int     pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            p1 = clamp(book.org_first + $urandom_range(0, 10 * DEG) - 5 * DEG);
            p2 = clamp(book.org_second + $urandom_range(0, 10 * DEG) - 5 * DEG);
         end else if (pick == 8) begin
            p1 = int'($urandom_range(0, 2 * COORD_MAX)) + COORD_MIN;
            p2 = book.org_second;
            if ($urandom_range(0, 1)) begin
               p2 = p1;
               p1 = book.org_first;
            end
         end else if (pick == 9) begin
            // differences near half a turn
            p1 = clamp(book.org_first + ($urandom_range(0, 1) ? 180 : -180) * DEG
                       + int'($urandom_range(0, 2 * DEG)) - DEG);
            p2 = clamp(book.org_second + ($urandom_range(0, 1) ? 180 : -180) * DEG
                       + int'($urandom_range(0, 2 * DEG)) - DEG);
         end else begin
            p1 = int'($urandom_range(0, 2 * COORD_MAX)) + COORD_MIN;
            p2 = int'($urandom_range(0, 2 * COORD_MAX)) + COORD_MIN;
         end
         send_request(p1, p2);
      end
   endtask

   initial begin
      longint o1, o2;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_point_first  <= '0;
      req_point_second <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= CSR_ORIGIN_FIRST;
      csr_data         <= '0;
      calm_req = 1'b0;
      calm_rsp = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default origin
      o1 = book.org_first;
      o2 = book.org_second;
      send_request(o1, o2);
      send_request(COORD_MAX, COORD_MAX);
      send_request(COORD_MIN, COORD_MIN);
      send_request(COORD_MAX, COORD_MIN);
      send_request(COORD_MIN, COORD_MAX);
      send_request(0, 0);
      send_request(-1, -1);
      send_request(o1 + 1, o2 + 1);
      send_request(o1 - 1, o2 - 1);
      send_request(o1 - 180 * DEG, o2 - 180 * DEG);
      send_request(o1 - 180 * DEG - 1, o2 - 180 * DEG + 1);
      send_request(o1 - 270 * DEG, o2 - 90 * DEG);
      send_request(o1, COORD_MIN);
      send_request(COORD_MIN, o2);
      drain();
      set_origin(COORD_MAX, COORD_MIN);
      send_request(COORD_MIN, COORD_MAX);
      send_request(COORD_MAX, COORD_MIN);
      send_request(0, 0);
      send_request(COORD_MAX - 1, COORD_MIN + 1);
      send_request(-1, 90 * DEG);

      for (int ph = 0; ph < 6; ph++) begin
         calm_req = (ph == 2);
         calm_rsp = (ph == 3);
         drain();
         repeat (4) @(posedge clock);
         case (ph)
            0: set_origin(COORD_MAX, COORD_MAX);
            1: set_origin(COORD_MIN, COORD_MIN);
            2: set_origin(0, 0);
            3: set_origin(90 * DEG, -90 * DEG);
            4: set_origin(int'($urandom_range(0, 2 * COORD_MAX)) + COORD_MIN,
                          int'($urandom_range(0, 2 * COORD_MAX)) + COORD_MIN);
            default: set_origin(longint'($signed(ORIGIN_FIRST_RESET)),
                                longint'($signed(ORIGIN_SECOND_RESET)));
         endcase
         random_requests(138);
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (book.errors == 0 && book.pending.size() == 0)
         $display("** geo_offset_haversine_core: PASSED **");
      else
         $display("** geo_offset_haversine_core: FAILED **");
      $finish;
   end

endmodule

### filelist.f
sv/geo_hav_pkg.sv
sv/geo_hav_term.sv
sv/geo_hav_sin.sv
sv/geo_hav_rad.sv
sv/geo_hav_asin_cell.sv
sv/geo_offset_haversine_core.sv
tb/tb_geo_offset_haversine_core.sv
